// ----- hdl/sprb_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// Stereo playout ring buffer package
// Shared constants, controller state type and the command bundle that the
// controller sends to the datapath.
// ============================================================================
package sprb_pkg;

    localparam int DEPTH_PAIRS_DEF = 1024;
    localparam int FRAME_PAIRS_DEF = 32;
    localparam int SAMPLE_W        = 16;
    localparam int PAIRS_W         = 11;
    localparam int PAIR_W          = 2 * SAMPLE_W;

    typedef enum logic {
        ST_IDLE,
        ST_PULL
    } t_state;

    typedef struct packed {
        logic push;
        logic pull_load;
        logic rd_en;
        logic rd_last;
        logic commit;
    } t_cmd;

endpackage

// ----- hdl/sprb_ram.sv -----
`timescale 1ns / 1ps
// ============================================================================
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ============================================================================
module sprb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/sprb_ctrl.sv -----
`timescale 1ns / 1ps
// ============================================================================
// Stereo playout ring buffer controller
// Accepts items, sequences the pair reads of a pulled frame and tells the
// datapath when to commit the frame.
// ============================================================================
module sprb_ctrl #(
    parameter int FRAME_PAIRS = sprb_pkg::FRAME_PAIRS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  logic           i_mode,
    output logic           busy,
    output sprb_pkg::t_cmd o_cmd
);

    localparam int CW = (FRAME_PAIRS > 1) ? $clog2(FRAME_PAIRS) : 1;

    sprb_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sprb_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        busy    = 1'b0;
        unique case (r_state)
            sprb_pkg::ST_IDLE: begin
                if (start) begin
                    if (i_mode) begin
                        o_cmd.pull_load = 1'b1;
                        n_cnt           = '0;
                        n_state         = sprb_pkg::ST_PULL;
                    end else begin
                        o_cmd.push = 1'b1;
                    end
                end
            end
            sprb_pkg::ST_PULL: begin
                busy        = 1'b1;
                o_cmd.rd_en = 1'b1;
                if (r_cnt == CW'(FRAME_PAIRS - 1)) begin
                    o_cmd.rd_last = 1'b1;
                    o_cmd.commit  = 1'b1;
                    n_state       = sprb_pkg::ST_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            default: begin
                n_state = sprb_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/sprb_datapath.sv -----
`timescale 1ns / 1ps
// ============================================================================
// Stereo playout ring buffer datapath
// Holds the ring pointers, occupancy and packet drop flag, writes pushed
// pairs into the sample RAM and forms the output pairs of a frame.
// ============================================================================
module sprb_datapath #(
    parameter int DEPTH_PAIRS = sprb_pkg::DEPTH_PAIRS_DEF,
    parameter int FRAME_PAIRS = sprb_pkg::FRAME_PAIRS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sprb_pkg::t_cmd                      i_cmd,
    input  logic signed [sprb_pkg::SAMPLE_W-1:0] i_left_sample,
    input  logic signed [sprb_pkg::SAMPLE_W-1:0] i_right_sample,
    input  logic                                i_is_stereo,
    input  logic                                i_packet_start,
    input  logic [sprb_pkg::PAIRS_W-1:0]        i_packet_pairs,
    input  logic                                i_dequeue,
    output logic                                o_valid,
    output logic signed [sprb_pkg::SAMPLE_W-1:0] o_left_out,
    output logic signed [sprb_pkg::SAMPLE_W-1:0] o_right_out,
    output logic                                o_underflow,
    output logic                                o_last_pair
);

    localparam int IW = $clog2(DEPTH_PAIRS);
    localparam int FW = $clog2(DEPTH_PAIRS + 1);
    localparam int SW = ((FW > sprb_pkg::PAIRS_W) ? FW : sprb_pkg::PAIRS_W) + 1;
    localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH_PAIRS);
    localparam logic [FW-1:0] DEPTH_F = FW'(DEPTH_PAIRS);
    localparam logic [FW-1:0] FRAME_F = FW'(FRAME_PAIRS);
    localparam logic [IW:0]   DEPTH_I = (IW + 1)'(DEPTH_PAIRS);

    logic [IW-1:0] r_wr_idx, n_wr_idx;
    logic [IW-1:0] r_rd_idx, n_rd_idx;
    logic [IW-1:0] r_rd_ptr, n_rd_ptr;
    logic [FW-1:0] r_fill, n_fill;
    logic          r_drop, n_drop;
    logic          r_uflow, n_uflow;
    logic          r_deq, n_deq;
    logic          r_out_valid, r_out_last;

    logic [SW-1:0]               sum_pairs;
    logic                        wr_en;
    logic [IW:0]                 wr_inc, rd_inc;
    logic [IW-1:0]               wr_next, rd_next;
    logic [sprb_pkg::PAIR_W-1:0] wr_data, rd_data;
    logic [sprb_pkg::SAMPLE_W-1:0] right_sel;

    assign sum_pairs = SW'(r_fill) + SW'(i_packet_pairs);
    assign wr_inc    = {1'b0, r_wr_idx} + 1'b1;
    assign wr_next   = (wr_inc == DEPTH_I) ? '0 : wr_inc[IW-1:0];
    assign rd_inc    = {1'b0, r_rd_ptr} + 1'b1;
    assign rd_next   = (rd_inc == DEPTH_I) ? '0 : rd_inc[IW-1:0];
    assign right_sel = i_is_stereo ? i_right_sample : i_left_sample;
    assign wr_data   = {right_sel, i_left_sample};

    always_comb begin
        n_drop   = r_drop;
        n_wr_idx = r_wr_idx;
        n_rd_idx = r_rd_idx;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        n_uflow  = r_uflow;
        n_deq    = r_deq;
        wr_en    = 1'b0;
        if (i_cmd.push) begin
            n_drop = i_packet_start ? (sum_pairs > DEPTH_S) : r_drop;
            if (!n_drop && (r_fill < DEPTH_F)) begin
                wr_en    = 1'b1;
                n_wr_idx = wr_next;
                n_fill   = r_fill + 1'b1;
            end
        end
        if (i_cmd.pull_load) begin
            n_rd_ptr = r_rd_idx;
            n_uflow  = r_fill < FRAME_F;
            n_deq    = i_dequeue;
        end
        if (i_cmd.rd_en) begin
            n_rd_ptr = rd_next;
        end
        if (i_cmd.commit && !r_uflow && r_deq) begin
            n_rd_idx = rd_next;
            n_fill   = r_fill - FRAME_F;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx    <= '0;
            r_rd_idx    <= '0;
            r_fill      <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
        end else begin
            r_wr_idx    <= n_wr_idx;
            r_rd_idx    <= n_rd_idx;
            r_fill      <= n_fill;
            r_drop      <= n_drop;
            r_out_valid <= i_cmd.rd_en;
            r_out_last  <= i_cmd.rd_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_ptr <= n_rd_ptr;
        r_uflow  <= n_uflow;
        r_deq    <= n_deq;
    end

    sprb_ram #(
        .WIDTH (sprb_pkg::PAIR_W),
        .DEPTH (DEPTH_PAIRS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_wr_idx),
        .i_wdata (wr_data),
        .i_re    (i_cmd.rd_en),
        .i_raddr (r_rd_ptr),
        .o_rdata (rd_data)
    );

    assign o_valid     = r_out_valid;
    assign o_left_out  = r_uflow ? '0 : signed'(rd_data[sprb_pkg::SAMPLE_W-1:0]);
    assign o_right_out = r_uflow ? '0 :
                         signed'(rd_data[sprb_pkg::PAIR_W-1:sprb_pkg::SAMPLE_W]);
    assign o_underflow = r_out_valid & r_uflow;
    assign o_last_pair = r_out_valid & r_out_last;

endmodule

// ----- hdl/stereo_playout_ring_buffer_core.sv -----
`timescale 1ns / 1ps
// ============================================================================
// Stereo playout ring buffer core
// Pushes may be accepted every cycle while no pull is in progress. A pull item holds
// busy while its frame is read, one sample RAM read per pair; its first pair appears
// once the pull state is entered and the RAM read data is registered, then one pair
// per cycle. The next item is accepted once the controller is back in idle after the
// last read of a pull; results cannot stall. Synchronous active-low reset clears the
// write and read indices, occupancy and the drop flag; the sample RAM is not cleared.
// ============================================================================
module stereo_playout_ring_buffer_core #(
    parameter int DEPTH_PAIRS = sprb_pkg::DEPTH_PAIRS_DEF,
    parameter int FRAME_PAIRS = sprb_pkg::FRAME_PAIRS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 i_mode,
    input  logic signed [sprb_pkg::SAMPLE_W-1:0] i_left_sample,
    input  logic signed [sprb_pkg::SAMPLE_W-1:0] i_right_sample,
    input  logic                                 i_is_stereo,
    input  logic                                 i_packet_start,
    input  logic [sprb_pkg::PAIRS_W-1:0]         i_packet_pairs,
    input  logic                                 i_dequeue,
    output logic                                 o_valid,
    output logic signed [sprb_pkg::SAMPLE_W-1:0] o_left_out,
    output logic signed [sprb_pkg::SAMPLE_W-1:0] o_right_out,
    output logic                                 o_underflow,
    output logic                                 o_last_pair
);

    sprb_pkg::t_cmd cmd;

    sprb_ctrl #(
        .FRAME_PAIRS (FRAME_PAIRS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_mode  (i_mode),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    sprb_datapath #(
        .DEPTH_PAIRS (DEPTH_PAIRS),
        .FRAME_PAIRS (FRAME_PAIRS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_left_sample  (i_left_sample),
        .i_right_sample (i_right_sample),
        .i_is_stereo    (i_is_stereo),
        .i_packet_start (i_packet_start),
        .i_packet_pairs (i_packet_pairs),
        .i_dequeue      (i_dequeue),
        .o_valid        (o_valid),
        .o_left_out     (o_left_out),
        .o_right_out    (o_right_out),
        .o_underflow    (o_underflow),
        .o_last_pair    (o_last_pair)
    );

    a_valid_in_pull: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("Output item outside of a frame read.");

    a_gap_after_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_pair |=> !o_valid)
        else $error("Output item directly after the last pair of a frame.");

    a_pull_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_mode |=> busy)
        else $error("Accepted pull did not start a frame read.");

    a_underflow_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_underflow |-> (o_left_out == '0) && (o_right_out == '0))
        else $error("Underflow frame carries nonzero samples.");

endmodule
